FILE: src/slx_pkg.sv
// slx_pkg: types, constants and helpers shared by the shell line lexer.
// No dependencies; compiled first.
`default_nettype none

package slx_pkg;

  // Default limits for the top-level parameters.
  localparam int TOKEN_LEN_MAX_DEF   = 255;
  localparam int TOKEN_COUNT_MAX_DEF = 1023;

  // Lower clamp bounds of the configuration values.
  localparam int TOKEN_LEN_MIN   = 3;
  localparam int TOKEN_COUNT_MIN = 1;

  // Configuration register indexes and reset values.
  localparam logic REG_MAX_TOKEN_LEN = 1'b0;
  localparam logic REG_TOKEN_CAP     = 1'b1;
  localparam logic [7:0] MAX_TOKEN_LEN_RST = 8'd100;
  localparam logic [9:0] TOKEN_CAP_RST     = 10'd1000;

  // Character codes.
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SQUOTE = 2'd1;
  localparam logic [1:0] ERR_DQUOTE = 2'd2;
  localparam logic [1:0] ERR_TOKENS = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_SQ     = 3'd2,
    MODE_DQ     = 3'd3,
    MODE_DQESC  = 3'd4,
    MODE_OPPEND = 3'd5,
    MODE_SKIP   = 3'd6
  } lex_mode_t;

  // Classified input byte, as held in the front queue.
  typedef struct packed {
    logic [7:0] char_in;
    logic       term;
    logic       ws;
    logic       op;
  } slx_item_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [7:0] len;
    logic [9:0] tokens;
  } slx_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_end;
    logic       line_done;
    logic [1:0] error_code;
    logic       last_of_item;
  } slx_result_t;

  function automatic slx_result_t mk_result(logic [7:0] b, logic has, logic te,
                                            logic done, logic [1:0] err);
    slx_result_t r;
    r.out_byte     = b;
    r.has_byte     = has;
    r.token_end    = te;
    r.line_done    = done;
    r.error_code   = err;
    r.last_of_item = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/slx_if.sv
// slx_in_if / slx_out_if: valid/ready channels of the shell line lexer.
// No dependencies.
`default_nettype none

interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source(output valid, char_in, end_of_line, input ready);
  modport sink(input valid, char_in, end_of_line, output ready);
endinterface

interface slx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       token_end;
  logic       line_done;
  logic [1:0] error_code;
  logic       last_of_item;

  modport source(output valid, out_byte, has_byte, token_end, line_done,
                 error_code, last_of_item, input ready);
  modport sink(input valid, out_byte, has_byte, token_end, line_done,
               error_code, last_of_item, output ready);
endinterface

`default_nettype wire

FILE: src/slx_front.sv
// slx_front: accepts input bytes, classifies them and queues them (2 deep).
// Depends on slx_pkg and slx_in_if.
`default_nettype none

module slx_front (
  input  wire logic                clk,
  input  wire logic                rst,
  slx_in_if.sink                   in_ch,
  output logic                     q_valid,
  output slx_pkg::slx_item_t       q_item,
  input  wire logic                q_pop
);

  slx_pkg::slx_item_t item_new;
  slx_pkg::slx_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    item_new.char_in = in_ch.char_in;
    item_new.term    = in_ch.end_of_line || (in_ch.char_in == slx_pkg::CH_NUL);
    item_new.ws      = in_ch.char_in inside {slx_pkg::CH_SPACE,
                                             [slx_pkg::CH_TAB:slx_pkg::CH_CR]};
    item_new.op      = in_ch.char_in inside {slx_pkg::CH_GT, slx_pkg::CH_LT,
                                             slx_pkg::CH_AMP, slx_pkg::CH_PIPE,
                                             slx_pkg::CH_DOLLAR};
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_item      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_new;
  end

endmodule

`default_nettype wire

FILE: src/slx_back.sv
// slx_back: lexer state machine plus a 2-entry result buffer.
// Depends on slx_pkg and slx_out_if.
`default_nettype none

module slx_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire slx_pkg::slx_cfg_t   cfg,
  input  wire logic                q_valid,
  input  wire slx_pkg::slx_item_t  q_item,
  output logic                     q_pop,
  slx_out_if.source                out_ch
);

  // lexer state
  slx_pkg::lex_mode_t lex_mode, lex_mode_next;
  logic [7:0] token_length, token_length_next;
  logic [9:0] token_count, token_count_next;
  logic [7:0] pending_operator, pending_operator_next;

  // token start helper
  logic               st_emit;
  slx_pkg::slx_result_t st_res;
  slx_pkg::lex_mode_t st_mode;
  logic [7:0]         st_len;
  logic [7:0]         st_pend;
  logic [9:0]         st_cnt;

  // results of the head item
  slx_pkg::slx_result_t res0, res1;
  logic [1:0]         n_res;

  logic [7:0] c;
  logic [7:0] word_lim;
  logic [7:0] len_inc;
  logic       word_end;
  logic       quote_full;
  logic       tok_full;

  // output buffer
  slx_pkg::slx_result_t slots [2];
  slx_pkg::slx_result_t slot0_next, slot1_next;
  logic [1:0] cnt, cnt_next, base;
  logic       pop;

  assign c          = q_item.char_in;
  assign word_lim   = cfg.len - 8'd1;
  assign len_inc    = token_length + 8'd1;
  assign word_end   = (len_inc >= word_lim);
  assign quote_full = ({1'b0, token_length} + 9'd2) >= {1'b0, cfg.len};
  assign tok_full   = (token_count >= cfg.tokens);

  // first byte of a token, lexed from between tokens
  always_comb begin
    st_emit = 1'b0;
    st_res  = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
    st_mode = slx_pkg::MODE_IDLE;
    st_len  = 8'd0;
    st_pend = pending_operator;
    st_cnt  = token_count;
    if (tok_full) begin
      st_emit = 1'b1;
      st_res  = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b0, slx_pkg::ERR_TOKENS);
      st_mode = slx_pkg::MODE_SKIP;
    end else begin
      st_cnt = token_count + 10'd1;
      if (c == slx_pkg::CH_DQUOTE) begin
        st_mode = slx_pkg::MODE_DQ;
      end else if (c == slx_pkg::CH_SQUOTE) begin
        st_mode = slx_pkg::MODE_SQ;
      end else if (q_item.op) begin
        st_emit = 1'b1;
        if (c == slx_pkg::CH_DOLLAR) begin
          st_res = slx_pkg::mk_result(c, 1'b1, 1'b1, 1'b0, slx_pkg::ERR_NONE);
        end else begin
          st_res  = slx_pkg::mk_result(c, 1'b1, 1'b0, 1'b0, slx_pkg::ERR_NONE);
          st_len  = 8'd1;
          st_pend = c;
          st_mode = slx_pkg::MODE_OPPEND;
        end
      end else begin
        st_emit = 1'b1;
        if (8'd1 >= word_lim) begin
          st_res = slx_pkg::mk_result(c, 1'b1, 1'b1, 1'b0, slx_pkg::ERR_NONE);
        end else begin
          st_res  = slx_pkg::mk_result(c, 1'b1, 1'b0, 1'b0, slx_pkg::ERR_NONE);
          st_len  = 8'd1;
          st_mode = slx_pkg::MODE_WORD;
        end
      end
    end
  end

  // next state
  always_comb begin
    lex_mode_next         = lex_mode;
    token_length_next     = token_length;
    token_count_next      = token_count;
    pending_operator_next = pending_operator;
    if (q_item.term) begin
      lex_mode_next     = slx_pkg::MODE_IDLE;
      token_length_next = 8'd0;
      token_count_next  = 10'd0;
    end else begin
      case (lex_mode)
        slx_pkg::MODE_WORD: begin
          if (q_item.ws) begin
            lex_mode_next     = slx_pkg::MODE_IDLE;
            token_length_next = 8'd0;
          end else if (q_item.op) begin
            lex_mode_next         = st_mode;
            token_length_next     = st_len;
            token_count_next      = st_cnt;
            pending_operator_next = st_pend;
          end else if (word_end) begin
            lex_mode_next     = slx_pkg::MODE_IDLE;
            token_length_next = 8'd0;
          end else begin
            token_length_next = len_inc;
          end
        end
        slx_pkg::MODE_SQ, slx_pkg::MODE_DQ, slx_pkg::MODE_DQESC: begin
          if ((lex_mode == slx_pkg::MODE_SQ && c == slx_pkg::CH_SQUOTE) ||
              (lex_mode == slx_pkg::MODE_DQ && c == slx_pkg::CH_DQUOTE)) begin
            lex_mode_next     = slx_pkg::MODE_IDLE;
            token_length_next = 8'd0;
          end else if (lex_mode == slx_pkg::MODE_DQ && c == slx_pkg::CH_BSLASH) begin
            lex_mode_next = slx_pkg::MODE_DQESC;
          end else if (quote_full) begin
            lex_mode_next     = slx_pkg::MODE_SKIP;
            token_length_next = 8'd0;
          end else begin
            token_length_next = len_inc;
            if (lex_mode == slx_pkg::MODE_DQESC) lex_mode_next = slx_pkg::MODE_DQ;
          end
        end
        slx_pkg::MODE_OPPEND: begin
          if (c == pending_operator || q_item.ws) begin
            lex_mode_next     = slx_pkg::MODE_IDLE;
            token_length_next = 8'd0;
          end else begin
            lex_mode_next         = st_mode;
            token_length_next     = st_len;
            token_count_next      = st_cnt;
            pending_operator_next = st_pend;
          end
        end
        slx_pkg::MODE_SKIP: begin
        end
        default: begin
          // idle; unused codes lex as idle
          lex_mode_next     = slx_pkg::MODE_IDLE;
          token_length_next = 8'd0;
          if (!q_item.ws) begin
            lex_mode_next         = st_mode;
            token_length_next     = st_len;
            token_count_next      = st_cnt;
            pending_operator_next = st_pend;
          end
        end
      endcase
    end
  end

  // results of the head item
  always_comb begin
    res0  = slx_pkg::mk_result(8'd0, 1'b0, 1'b1, 1'b0, slx_pkg::ERR_NONE);
    res1  = st_res;
    n_res = 2'd0;
    if (q_item.term) begin
      n_res = 2'd1;
      case (lex_mode)
        slx_pkg::MODE_WORD, slx_pkg::MODE_OPPEND:
          res0 = slx_pkg::mk_result(8'd0, 1'b0, 1'b1, 1'b1, slx_pkg::ERR_NONE);
        slx_pkg::MODE_SQ:
          res0 = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b1, slx_pkg::ERR_SQUOTE);
        slx_pkg::MODE_DQ, slx_pkg::MODE_DQESC:
          res0 = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b1, slx_pkg::ERR_DQUOTE);
        default:
          res0 = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b1, slx_pkg::ERR_NONE);
      endcase
    end else begin
      case (lex_mode)
        slx_pkg::MODE_WORD: begin
          if (q_item.ws) begin
            n_res = 2'd1;
          end else if (q_item.op) begin
            n_res = st_emit ? 2'd2 : 2'd1;
          end else begin
            n_res = 2'd1;
            res0  = slx_pkg::mk_result(c, 1'b1, word_end, 1'b0, slx_pkg::ERR_NONE);
          end
        end
        slx_pkg::MODE_SQ, slx_pkg::MODE_DQ, slx_pkg::MODE_DQESC: begin
          if ((lex_mode == slx_pkg::MODE_SQ && c == slx_pkg::CH_SQUOTE) ||
              (lex_mode == slx_pkg::MODE_DQ && c == slx_pkg::CH_DQUOTE)) begin
            n_res = 2'd1;
          end else if (lex_mode == slx_pkg::MODE_DQ && c == slx_pkg::CH_BSLASH) begin
            n_res = 2'd0;
          end else if (quote_full) begin
            n_res = 2'd1;
            res0  = slx_pkg::mk_result(8'd0, 1'b0, 1'b0, 1'b0,
                                       (lex_mode == slx_pkg::MODE_SQ) ?
                                       slx_pkg::ERR_SQUOTE : slx_pkg::ERR_DQUOTE);
          end else begin
            n_res = 2'd1;
            res0  = slx_pkg::mk_result(c, 1'b1, 1'b0, 1'b0, slx_pkg::ERR_NONE);
          end
        end
        slx_pkg::MODE_OPPEND: begin
          if (c == pending_operator) begin
            n_res = 2'd1;
            res0  = slx_pkg::mk_result(c, 1'b1, 1'b1, 1'b0, slx_pkg::ERR_NONE);
          end else if (q_item.ws || !st_emit) begin
            n_res = 2'd1;
          end else begin
            n_res = 2'd2;
          end
        end
        slx_pkg::MODE_SKIP: begin
          n_res = 2'd0;
        end
        default: begin
          res0  = st_res;
          n_res = (!q_item.ws && st_emit) ? 2'd1 : 2'd0;
        end
      endcase
    end
    if (n_res == 2'd1) res0.last_of_item = 1'b1;
    if (n_res == 2'd2) res1.last_of_item = 1'b1;
  end

  // result buffer: the head item is taken once its results fit
  assign pop   = out_ch.valid && out_ch.ready;
  assign base  = cnt - {1'b0, pop};
  assign q_pop = q_valid && (({1'b0, base} + {1'b0, n_res}) <= 3'd2);

  always_comb begin
    slot0_next = pop ? slots[1] : slots[0];
    slot1_next = slots[1];
    cnt_next   = base;
    if (q_pop) begin
      cnt_next = base + n_res;
      if (base == 2'd0) begin
        if (n_res != 2'd0) slot0_next = res0;
        if (n_res == 2'd2) slot1_next = res1;
      end else begin
        if (n_res != 2'd0) slot1_next = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= slx_pkg::MODE_IDLE;
      token_length     <= 8'd0;
      token_count      <= 10'd0;
      pending_operator <= 8'd0;
      cnt              <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (q_pop) begin
        lex_mode         <= lex_mode_next;
        token_length     <= token_length_next;
        token_count      <= token_count_next;
        pending_operator <= pending_operator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    slots[0] <= slot0_next;
    slots[1] <= slot1_next;
  end

  assign out_ch.valid        = (cnt != 2'd0);
  assign out_ch.out_byte     = slots[0].out_byte;
  assign out_ch.has_byte     = slots[0].has_byte;
  assign out_ch.token_end    = slots[0].token_end;
  assign out_ch.line_done    = slots[0].line_done;
  assign out_ch.error_code   = slots[0].error_code;
  assign out_ch.last_of_item = slots[0].last_of_item;

endmodule

`default_nettype wire

FILE: src/shell_line_lexer.sv
// shell_line_lexer: streaming shell command-line tokenizer, top level.
// Depends on slx_pkg, slx_if, slx_front and slx_back.
//
// Bytes of one command line come in on in_ch, one byte per transaction, and
// the line is closed by a transaction with end_of_line set (a NUL byte also
// ends the line). Tokens go out on out_ch as a stream of byte transactions;
// token_end marks the end of a token, line_done the end of the line, and
// error_code flags a bad quote or too many tokens, after which the rest of
// the line is skipped. last_of_item marks the final output transaction that
// a given input byte caused. Throughput is one byte per clock while
// out_ch.ready stays high and each byte produces at most one output
// transaction; a byte that produces two (a word closed by an operator, or a
// pending operator closed by a byte other than a quote, whitespace or itself)
// needs both entries of the 2-entry output buffer, so it is taken only once
// the buffer is empty. The first result of a received byte passes through the
// 2-deep input queue and then the output buffer register. in_ch.ready depends
// only on the queue fill, so an output stall reaches the input via a full queue.
// Write the token length limit (index 0) and the token count limit (index 1)
// only while idle; out-of-range values are clamped to [3, TOKEN_LEN_MAX] and
// [1, TOKEN_COUNT_MAX].
`default_nettype none

module shell_line_lexer #(
  parameter int TOKEN_LEN_MAX   = slx_pkg::TOKEN_LEN_MAX_DEF,
  parameter int TOKEN_COUNT_MAX = slx_pkg::TOKEN_COUNT_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [9:0] cfg_data,
  slx_in_if.sink          in_ch,
  slx_out_if.source       out_ch
);

  // raw configuration registers
  logic [7:0] max_token_len;
  logic [9:0] token_cap;

  slx_pkg::slx_cfg_t  cfg;
  logic               q_valid;
  slx_pkg::slx_item_t q_item;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_len <= slx_pkg::MAX_TOKEN_LEN_RST;
      token_cap     <= slx_pkg::TOKEN_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slx_pkg::REG_MAX_TOKEN_LEN: max_token_len <= cfg_data[7:0];
        slx_pkg::REG_TOKEN_CAP:     token_cap     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp into the supported ranges
  always_comb begin
    cfg.len = max_token_len;
    if (max_token_len < 8'(slx_pkg::TOKEN_LEN_MIN))
      cfg.len = 8'(slx_pkg::TOKEN_LEN_MIN);
    else if (max_token_len > 8'(TOKEN_LEN_MAX))
      cfg.len = 8'(TOKEN_LEN_MAX);
    cfg.tokens = token_cap;
    if (token_cap < 10'(slx_pkg::TOKEN_COUNT_MIN))
      cfg.tokens = 10'(slx_pkg::TOKEN_COUNT_MIN);
    else if (token_cap > 10'(TOKEN_COUNT_MAX))
      cfg.tokens = 10'(TOKEN_COUNT_MAX);
  end

  // front: take and classify bytes, queue them
  slx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: lexer state machine and output buffer
  slx_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // back never takes from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a full input queue stalls the input only while an item waits for the back
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with empty queue");

  // end of line is always the last result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.line_done) |-> out_ch.last_of_item)
    else $error("line_done result not last of item");

  // error results carry no token byte
  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.error_code != slx_pkg::ERR_NONE) |-> !out_ch.has_byte)
    else $error("error result with token byte");

endmodule

`default_nettype wire
